// ===== rtl/core/iba_pkg.sv =====
// shared types, constants and the sequencer program of the inode bitmap allocator
`timescale 1ns / 1ps

package iba_pkg;

    // field widths and map organization
    localparam int NUM_W        = 13;
    localparam int WORD_BITS    = 64;
    localparam int BIT_IDX_W    = 6;
    localparam int MAP_BITS_DEF = 4096;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // request opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // program step addresses
    typedef logic [3:0] step_t;
    localparam step_t STEP_CLR       = 4'd0;
    localparam step_t STEP_IDLE      = 4'd1;
    localparam step_t STEP_DISPATCH  = 4'd2;
    localparam step_t STEP_READ      = 4'd3;
    localparam step_t STEP_TEST      = 4'd4;
    localparam step_t STEP_NEXT      = 4'd5;
    localparam step_t STEP_FULL      = 4'd6;
    localparam step_t STEP_GRANT     = 4'd7;
    localparam step_t STEP_REL_CHECK = 4'd8;
    localparam step_t STEP_REL_CLEAR = 4'd9;
    localparam step_t STEP_REL_BAD   = 4'd10;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER     = 4'd0,
        COND_ALWAYS    = 4'd1,
        COND_ACCEPT    = 4'd2,
        COND_LAST_WORD = 4'd3,
        COND_OP_REL    = 4'd4,
        COND_HIT       = 4'd5,
        COND_MORE      = 4'd6,
        COND_BAD       = 4'd7,
        COND_OUT_FREE  = 4'd8
    } cond_t;

    // word address operations
    typedef enum logic [1:0] {
        ADDR_HOLD = 2'd0,
        ADDR_INC  = 2'd1,
        ADDR_LOAD = 2'd2
    } addr_op_t;

    // map write operations
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ZERO  = 2'd1,
        WR_SET   = 2'd2,
        WR_CLEAR = 2'd3
    } wr_op_t;

    // result register loads
    typedef enum logic [2:0] {
        OUT_NONE  = 3'd0,
        OUT_FULL  = 3'd1,
        OUT_GRANT = 3'd2,
        OUT_OK    = 3'd3,
        OUT_BAD   = 3'd4
    } out_op_t;

    // one control word
    typedef struct packed {
        step_t    target;
        cond_t    cond;
        logic     stay;
        logic     in_ready;
        addr_op_t addr_op;
        wr_op_t   wr_op;
        logic     hit_load;
        out_op_t  out_op;
    } ctrl_word_t;

    // program rom: taken condition jumps to target, else stay or step on
    function automatic ctrl_word_t ctrl_rom(input step_t pc);
        ctrl_word_t cw;
        cw = '{target: STEP_IDLE, cond: COND_ALWAYS, stay: 1'b0, in_ready: 1'b0,
               addr_op: ADDR_HOLD, wr_op: WR_NONE, hit_load: 1'b0, out_op: OUT_NONE};
        case (pc)
            STEP_CLR:
            begin
                cw.cond    = COND_LAST_WORD;
                cw.stay    = 1'b1;
                cw.addr_op = ADDR_INC;
                cw.wr_op   = WR_ZERO;
            end
            STEP_IDLE:
            begin
                cw.target   = STEP_DISPATCH;
                cw.cond     = COND_ACCEPT;
                cw.stay     = 1'b1;
                cw.in_ready = 1'b1;
                cw.addr_op  = ADDR_LOAD;
            end
            STEP_DISPATCH:
            begin
                cw.target = STEP_REL_CHECK;
                cw.cond   = COND_OP_REL;
            end
            STEP_READ:
            begin
                cw.cond = COND_NEVER;
            end
            STEP_TEST:
            begin
                cw.target   = STEP_GRANT;
                cw.cond     = COND_HIT;
                cw.hit_load = 1'b1;
            end
            STEP_NEXT:
            begin
                cw.target  = STEP_READ;
                cw.cond    = COND_MORE;
                cw.addr_op = ADDR_INC;
            end
            STEP_FULL:
            begin
                cw.cond   = COND_OUT_FREE;
                cw.stay   = 1'b1;
                cw.out_op = OUT_FULL;
            end
            STEP_GRANT:
            begin
                cw.cond   = COND_OUT_FREE;
                cw.stay   = 1'b1;
                cw.wr_op  = WR_SET;
                cw.out_op = OUT_GRANT;
            end
            STEP_REL_CHECK:
            begin
                cw.target = STEP_REL_BAD;
                cw.cond   = COND_BAD;
            end
            STEP_REL_CLEAR:
            begin
                cw.cond   = COND_OUT_FREE;
                cw.stay   = 1'b1;
                cw.wr_op  = WR_CLEAR;
                cw.out_op = OUT_OK;
            end
            STEP_REL_BAD:
            begin
                cw.cond   = COND_OUT_FREE;
                cw.stay   = 1'b1;
                cw.out_op = OUT_BAD;
            end
            default:
            begin
                cw.cond = COND_ALWAYS;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/inode_bitmap_allocator.sv =====
// top level of the inode bitmap allocator: microcoded sequencer over a word-wide used map
`timescale 1ns / 1ps

// First-fit inode slot allocator. The used map is kept in a single-port memory of
// 64-bit words (ceil(MAP_BITS/64) words), one bit per slot, slot k being number k+1.
// After reset a clearing pass writes one word a cycle over all of these words,
// during which s_tready stays low; cfg writes are taken at any time. One request
// is worked at a time. An allocate reads the map word by word through the memory
// port, in the steps read, test and next for each word, up to the word that holds
// a free slot or the last word under the limit. A finished result sits in the
// output register, and the next request is accepted while it waits. Effective
// limit is min(slot_limit, MAP_BITS).
module inode_bitmap_allocator #(
    parameter int MAP_BITS = iba_pkg::MAP_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // slot_limit register
    input  logic                     cfg_wr_en,
    input  logic [iba_pkg::NUM_W-1:0] cfg_wr_data,
    // request channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [12:0] slot_number, [15:13] zero
    input  logic                     s_tuser,   // [0] opcode
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // [12:0] granted_number, [15:13] zero
    output logic [1:0]               m_tuser    // [1:0] status
);

    localparam int NUM_W     = iba_pkg::NUM_W;
    localparam int WB        = iba_pkg::WORD_BITS;
    localparam int BIW       = iba_pkg::BIT_IDX_W;
    localparam int MAP_WORDS = (MAP_BITS + WB - 1) / WB;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LIM_W     = ($clog2(MAP_BITS + 1) > NUM_W) ? $clog2(MAP_BITS + 1) : NUM_W;
    localparam int NW        = LIM_W + 2;
    localparam logic [LIM_W-1:0] MAP_LIM = LIM_W'(MAP_BITS);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

    // sequencer and datapath registers
    iba_pkg::step_t         pc_reg, pc_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [NUM_W-1:0]       slot_limit_reg;
    logic                   op_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [BIW-1:0]         hit_idx_reg;
    logic [WB-1:0]          rdata_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             status_reg;
    logic [NUM_W-1:0]       granted_reg;

    logic [WB-1:0]          map_mem [MAP_WORDS];

    iba_pkg::ctrl_word_t    cw;
    logic                   in_fire;
    logic                   out_free;
    logic                   out_load;
    logic                   cond_true;
    logic [LIM_W-1:0]       lim;
    logic [NW-1:0]          base;
    logic [NW-1:0]          lim_n;
    logic [NW-1:0]          rem_full;
    logic [BIW:0]           rem_sat;
    logic [WB-1:0]          lim_mask;
    logic [WB-1:0]          free_bits;
    logic                   word_hit;
    logic [BIW-1:0]         hit_idx;
    logic [NUM_W-1:0]       req_num;
    logic [NUM_W-1:0]       slot_m1;
    logic [NW-1:0]          rel_word;
    logic [NUM_W-1:0]       num_m1;
    logic [WB-1:0]          wdata;
    logic                   mem_we;
    logic [NW-1:0]          grant_sum;

    // current control word
    assign cw       = iba_pkg::ctrl_rom(pc_reg);
    assign s_tready = cw.in_ready;
    assign in_fire  = s_tvalid & cw.in_ready;
    assign out_free = ~m_valid_reg | m_tready;
    assign out_load = (cw.out_op != iba_pkg::OUT_NONE) & out_free;

    // effective limit and current word base
    assign lim   = (LIM_W'(slot_limit_reg) > MAP_LIM) ? MAP_LIM : LIM_W'(slot_limit_reg);
    assign lim_n = NW'(lim);
    assign base  = NW'({addr_reg, {BIW{1'b0}}});

    // slots of the current word that lie under the limit
    assign rem_full = lim_n - base;
    always_comb
    begin
        if (lim_n <= base)
            rem_sat = '0;
        else if (rem_full >= NW'(WB))
            rem_sat = (BIW+1)'(WB);
        else
            rem_sat = rem_full[BIW:0];
        for (int i = 0; i < WB; i++)
            lim_mask[i] = ((BIW+1)'(i) < rem_sat);
    end

    // first free slot in the word
    assign free_bits = ~rdata_reg & lim_mask;
    assign word_hit  = |free_bits;
    always_comb
    begin
        hit_idx = '0;
        for (int i = WB - 1; i >= 0; i--)
            if (free_bits[i])
                hit_idx = BIW'(i);
    end

    // word of a released slot
    assign req_num  = s_tdata[NUM_W-1:0];
    assign slot_m1  = req_num - NUM_W'(1);
    assign rel_word = NW'(slot_m1) >> BIW;
    assign num_m1   = num_reg - NUM_W'(1);

    // jump condition
    always_comb
    begin
        case (cw.cond)
            iba_pkg::COND_NEVER:     cond_true = 1'b0;
            iba_pkg::COND_ALWAYS:    cond_true = 1'b1;
            iba_pkg::COND_ACCEPT:    cond_true = in_fire;
            iba_pkg::COND_LAST_WORD: cond_true = (addr_reg == LAST_WORD);
            iba_pkg::COND_OP_REL:    cond_true = (op_reg == iba_pkg::OP_RELEASE);
            iba_pkg::COND_HIT:       cond_true = word_hit;
            iba_pkg::COND_MORE:      cond_true = ((base + NW'(WB)) < lim_n);
            iba_pkg::COND_BAD:       cond_true = (num_reg == '0) || (NW'(num_reg) > lim_n);
            iba_pkg::COND_OUT_FREE:  cond_true = out_free;
            default:                 cond_true = 1'b0;
        endcase
    end

    // step counter and word address
    always_comb
    begin
        if (cond_true)
            pc_next = cw.target;
        else if (cw.stay)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + iba_pkg::step_t'(1);

        case (cw.addr_op)
            iba_pkg::ADDR_INC:  addr_next = addr_reg + ADDR_W'(1);
            iba_pkg::ADDR_LOAD: addr_next = in_fire
                                          ? ((s_tuser == iba_pkg::OP_RELEASE)
                                             ? rel_word[ADDR_W-1:0] : '0)
                                          : addr_reg;
            default:            addr_next = addr_reg;
        endcase
    end

    // map write data
    always_comb
    begin
        mem_we = 1'b1;
        case (cw.wr_op)
            iba_pkg::WR_ZERO:  wdata = '0;
            iba_pkg::WR_SET:   wdata = rdata_reg | (WB'(1) << hit_idx_reg);
            iba_pkg::WR_CLEAR: wdata = rdata_reg & ~(WB'(1) << num_m1[BIW-1:0]);
            default:
            begin
                wdata  = rdata_reg;
                mem_we = 1'b0;
            end
        endcase
    end

    // result register control
    always_comb
    begin
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    assign grant_sum = base + NW'(hit_idx_reg) + NW'(1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= iba_pkg::STEP_CLR;
            addr_reg       <= '0;
            slot_limit_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                slot_limit_reg <= cfg_wr_data;
        end
    end

    // request capture, hit index and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= s_tuser;
            num_reg <= req_num;
        end
        if (cw.hit_load)
            hit_idx_reg <= hit_idx;
        if (out_load)
        begin
            case (cw.out_op)
                iba_pkg::OUT_FULL:
                begin
                    status_reg  <= iba_pkg::ST_FULL;
                    granted_reg <= '0;
                end
                iba_pkg::OUT_GRANT:
                begin
                    status_reg  <= iba_pkg::ST_OK;
                    granted_reg <= grant_sum[NUM_W-1:0];
                end
                iba_pkg::OUT_BAD:
                begin
                    status_reg  <= iba_pkg::ST_BAD;
                    granted_reg <= '0;
                end
                default:
                begin
                    status_reg  <= iba_pkg::ST_OK;
                    granted_reg <= '0;
                end
            endcase
        end
    end

    // used map memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[addr_reg] <= wdata;
        rdata_reg <= map_mem[addr_reg];
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - NUM_W){1'b0}}, granted_reg};
    assign m_tuser  = status_reg;

endmodule

// ===== rtl/core/iba_checker.sv =====
// port checks for the inode bitmap allocator and their bind
`timescale 1ns / 1ps

module iba_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [15:0]               m_tdata,
    input logic [1:0]                m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // only the three defined status codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == iba_pkg::ST_OK || m_tuser == iba_pkg::ST_FULL ||
                      m_tuser == iba_pkg::ST_BAD))
        else $error("undefined status code");

    // a failed request grants no number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != iba_pkg::ST_OK |-> m_tdata == 16'd0)
        else $error("number granted on failure");

    // one request at a time: ready drops right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

endmodule

bind inode_bitmap_allocator iba_checker u_iba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
